// ===== sv/atd_pkg.sv =====
// Shared types and constants for the alarm table tick dispatch block.
package atd_pkg;

    localparam int TICK_W   = 32;
    localparam int SECS_W   = 22;
    localparam int USECS_W  = 20;
    localparam int REM_W    = 23;
    localparam int STATUS_W = 3;

    localparam int MS_PER_SEC  = 1000;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // x/1000 == (x >> 3) / 125; the /125 is a reciprocal multiply, exact for 29-bit operands
    localparam int PRE_SHIFT   = 3;
    localparam int MUL_X_W     = TICK_W - PRE_SHIFT;
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 36;
    localparam int MUL_W       = MUL_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_ADD_WR,
        S_REP_OUT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    tick_inc;
        logic    scan_run;
        logic    take;
        logic    clr_hit;
        logic    pend_push;
        logic    mul_go;
        logic    wr_slot;
        logic    emit;
        status_t emit_code;
        logic    emit_rem;
        logic    emit_last;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t kind;
        logic hit;
        logic scan_end;
        logic cap;
        logic due_ge;
        logic pend_vld;
    } ctl_stat_t;

endpackage

// ===== sv/atd_ctrl.sv =====
// Controller state machine: sequences slot scans, arithmetic and result strobes.
module atd_ctrl
    import atd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cmd_t      command,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_code = ST_ADDED;
        busy          = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.tick_inc = (command == CMD_TICK);
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                unique case (stat.kind)
                    CMD_ADD:
                    begin
                        if (stat.hit)
                        begin
                            cmd.take   = 1'b1;
                            state_next = S_MUL;
                        end
                        else if (stat.scan_end)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = ST_FULL;
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    CMD_CANCEL, CMD_REPORT:
                    begin
                        if (stat.hit)
                        begin
                            cmd.take    = 1'b1;
                            cmd.clr_hit = 1'b1;
                            if (stat.kind == CMD_REPORT && stat.due_ge)
                            begin
                                state_next = S_MUL;
                            end
                            else
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_code = ST_CANCELLED;
                                cmd.emit_last = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                        else if (stat.scan_end)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = ST_NOT_FOUND;
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (stat.hit)
                        begin
                            // the held expiry goes out now; it is not the last one
                            cmd.clr_hit   = 1'b1;
                            cmd.pend_push = 1'b1;
                            cmd.emit      = stat.pend_vld;
                            cmd.emit_code = ST_EXPIRED;
                            if (stat.cap)
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        else if (stat.scan_end)
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = (stat.kind == CMD_ADD) ? S_ADD_WR : S_REP_OUT;
            end
            S_ADD_WR:
            begin
                cmd.wr_slot   = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_code = ST_ADDED;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_REP_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_code = ST_CANCELLED;
                cmd.emit_rem  = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_FLUSH:
            begin
                cmd.emit      = stat.pend_vld;
                cmd.emit_code = ST_EXPIRED;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/atd_dpath.sv =====
// Datapath: slot memories, used bits, tick counter, scan pipeline, divider and result registers.
module atd_dpath
    import atd_pkg::*;
#(
    parameter int ALARM_SLOTS   = 16,
    parameter int EVENT_ID_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctl_cmd_t                 cmd,
    output ctl_stat_t                stat,
    input  cmd_t                     command,
    input  logic [EVENT_ID_BITS-1:0] event_id,
    input  logic [SECS_W-1:0]        delay_secs,
    input  logic [USECS_W-1:0]       delay_usecs,
    output logic                     result_strobe,
    output logic [STATUS_W-1:0]      status,
    output logic [EVENT_ID_BITS-1:0] alarm_event,
    output logic [REM_W-1:0]         remaining_secs,
    output logic                     last
);

    localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int PTR_W  = SLOT_W + 1;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(ALARM_SLOTS);

    // slot storage
    logic [EVENT_ID_BITS-1:0] slot_event_mem [ALARM_SLOTS];
    logic [TICK_W-1:0]        slot_due_mem   [ALARM_SLOTS];
    logic [ALARM_SLOTS-1:0]   slot_used_reg;

    logic [TICK_W-1:0]        tick_now_reg;

    // captured request
    cmd_t                     kind_reg;
    logic [EVENT_ID_BITS-1:0] ev_reg;
    logic [SECS_W-1:0]        secs_reg;
    logic [USECS_W-1:0]       usecs_reg;

    // scan pipeline
    logic [PTR_W-1:0]         ptr_reg;
    logic [SLOT_W-1:0]        ptr_idx;
    logic                     ptr_live;
    logic                     p1_vld_reg;
    logic [SLOT_W-1:0]        p1_idx_reg;
    logic                     p1_used_reg;
    logic [EVENT_ID_BITS-1:0] rd_event_reg;
    logic [TICK_W-1:0]        rd_due_reg;
    logic                     match;

    logic [SLOT_W-1:0]        slot_sel_reg;
    logic [TICK_W-1:0]        diff_reg;

    logic [MUL_X_W-1:0]       mul_x;
    logic [MUL_W-1:0]         mul_prod_reg;
    logic [TICK_W-1:0]        sec_prod_reg;
    logic [REM_W-1:0]         quot;
    logic [TICK_W-1:0]        due_new;

    logic                     pend_vld_reg;
    logic [EVENT_ID_BITS-1:0] pend_event_reg;
    logic [CNT_W-1:0]         count_reg;

    logic                     strobe_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [EVENT_ID_BITS-1:0] event_out_reg;
    logic [REM_W-1:0]         rem_reg;
    logic                     last_reg;

    assign ptr_idx  = ptr_reg[SLOT_W-1:0];
    assign ptr_live = (ptr_reg != PTR_END);

    always_comb
    begin
        unique case (kind_reg)
            CMD_ADD:              match = !p1_used_reg;
            CMD_CANCEL, CMD_REPORT: match = p1_used_reg && (rd_event_reg == ev_reg);
            CMD_TICK:             match = p1_used_reg && (rd_due_reg <= tick_now_reg);
            default:              match = 1'b0;
        endcase
    end

    assign stat.kind     = kind_reg;
    assign stat.hit      = p1_vld_reg && match;
    assign stat.scan_end = !ptr_live && !p1_vld_reg;
    assign stat.cap      = (count_reg == CNT_W'(MAX_RESULTS - 1));
    assign stat.due_ge   = (rd_due_reg >= tick_now_reg);
    assign stat.pend_vld = pend_vld_reg;

    // shared /1000 unit: add uses the microseconds, report uses the time left
    assign mul_x   = (kind_reg == CMD_ADD) ? MUL_X_W'(usecs_reg[USECS_W-1:PRE_SHIFT])
                                           : diff_reg[TICK_W-1:PRE_SHIFT];
    assign quot    = mul_prod_reg[RECIP_SHIFT +: REM_W];
    assign due_new = sec_prod_reg + TICK_W'(quot) + tick_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg  <= '0;
            slot_used_reg <= '0;
            kind_reg      <= CMD_ADD;
            ptr_reg       <= '0;
            p1_vld_reg    <= 1'b0;
            pend_vld_reg  <= 1'b0;
            count_reg     <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.tick_inc)
            begin
                tick_now_reg <= tick_now_reg + TICK_W'(1);
            end
            if (cmd.clr_hit)
            begin
                slot_used_reg[p1_idx_reg] <= 1'b0;
            end
            if (cmd.wr_slot)
            begin
                slot_used_reg[slot_sel_reg] <= 1'b1;
            end
            if (cmd.load)
            begin
                kind_reg <= command;
            end
            if (cmd.load)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.scan_run && ptr_live)
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
            p1_vld_reg <= cmd.scan_run && ptr_live;
            if (cmd.load)
            begin
                pend_vld_reg <= 1'b0;
                count_reg    <= '0;
            end
            else if (cmd.pend_push)
            begin
                pend_vld_reg <= 1'b1;
                count_reg    <= count_reg + CNT_W'(1);
            end
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ev_reg    <= event_id;
            secs_reg  <= delay_secs;
            usecs_reg <= delay_usecs;
        end
        p1_idx_reg   <= ptr_idx;
        p1_used_reg  <= slot_used_reg[ptr_idx];
        rd_event_reg <= slot_event_mem[ptr_idx];
        rd_due_reg   <= slot_due_mem[ptr_idx];
        if (cmd.wr_slot)
        begin
            slot_event_mem[slot_sel_reg] <= ev_reg;
            slot_due_mem[slot_sel_reg]   <= due_new;
        end
        if (cmd.take)
        begin
            slot_sel_reg <= p1_idx_reg;
            diff_reg     <= rd_due_reg - tick_now_reg;
        end
        if (cmd.mul_go)
        begin
            mul_prod_reg <= MUL_W'(mul_x) * MUL_W'(RECIP_125);
            sec_prod_reg <= TICK_W'(secs_reg) * TICK_W'(MS_PER_SEC);
        end
        if (cmd.pend_push)
        begin
            pend_event_reg <= rd_event_reg;
        end
        if (cmd.emit)
        begin
            status_reg    <= cmd.emit_code;
            event_out_reg <= (cmd.emit_code == ST_EXPIRED) ? pend_event_reg : ev_reg;
            rem_reg       <= cmd.emit_rem ? (quot + REM_W'(1)) : '0;
            last_reg      <= cmd.emit_last;
        end
    end

    assign result_strobe  = strobe_reg;
    assign status         = status_reg;
    assign alarm_event    = event_out_reg;
    assign remaining_secs = rem_reg;
    assign last           = last_reg;

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        tick_now_reg != $past(tick_now_reg) |-> tick_now_reg == $past(tick_now_reg) + TICK_W'(1))
        else $error("tick counter moved by more than one");

    a_slot_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_slot |=> slot_used_reg[$past(slot_sel_reg)])
        else $error("added slot not marked used");

endmodule

// ===== sv/alarm_table_tick_dispatch_unit.sv =====
// Top level of the alarm table tick dispatch block: controller plus datapath.
//
//  channel   handshake              payload
//  request   start / busy           command, event_id, delay_secs, delay_usecs
//  result    result_strobe (1 cyc)  status, alarm_event, remaining_secs, last
//
// One request at a time. The alarm memory is scanned one slot per cycle through a
// two-stage read pipeline; an add or a reporting cancel then also passes through the
// shared /1000 multiplier state. A tick emits up to 16 expiries, one at a time as found;
// the last is flagged when the scan ends or the 16th expiry is taken.
// Reset clears the tick counter and all used bits at once; no memory sweep is needed.
// Results cannot be held off: each strobe lasts exactly one cycle.
module alarm_table_tick_dispatch_unit
    import atd_pkg::*;
#(
    parameter int ALARM_SLOTS   = 16,
    parameter int EVENT_ID_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic [EVENT_ID_BITS-1:0] event_id,
    input  logic [SECS_W-1:0]        delay_secs,
    input  logic [USECS_W-1:0]       delay_usecs,
    output logic                     result_strobe,
    output logic [STATUS_W-1:0]      status,
    output logic [EVENT_ID_BITS-1:0] alarm_event,
    output logic [REM_W-1:0]         remaining_secs,
    output logic                     last
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;
    cmd_t      command_in;

    assign command_in = cmd_t'(command);

    atd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command_in),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    atd_dpath #(
        .ALARM_SLOTS   (ALARM_SLOTS),
        .EVENT_ID_BITS (EVENT_ID_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command_in),
        .event_id       (event_id),
        .delay_secs     (delay_secs),
        .delay_usecs    (delay_usecs),
        .result_strobe  (result_strobe),
        .status         (status),
        .alarm_event    (alarm_event),
        .remaining_secs (remaining_secs),
        .last           (last)
    );

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && status != ST_EXPIRED |-> last)
        else $error("non-expiry result not flagged last");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !result_strobe)
        else $error("result follows the last result of a request");

endmodule

// ===== test/tb_alarm_table_tick_dispatch_unit.sv =====
// Testbench for the alarm table tick dispatch unit: directed and random requests checked against a table model.
module tb_alarm_table_tick_dispatch_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import atd_pkg::*;

    localparam int SLOTS       = 16;
    localparam int ID_W        = 16;
    localparam int US_PER_MS   = 1000;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        cmd_t                cmd;
        bit [ID_W-1:0]       ev;
        bit [SECS_W-1:0]     secs;
        bit [USECS_W-1:0]    usecs;
        int unsigned         gap;
        bit                  drain;
    } request_t;

    typedef struct {
        status_t             status;
        bit [ID_W-1:0]       ev;
        bit [REM_W-1:0]      rem;
        bit                  last;
        int unsigned         stamp;
    } alarm_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           command = 2'b00;
    logic [ID_W-1:0]      event_id = '0;
    logic [SECS_W-1:0]    delay_secs = '0;
    logic [USECS_W-1:0]   delay_usecs = '0;
    logic                 result_strobe;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      alarm_event;
    logic [REM_W-1:0]     remaining_secs;
    logic                 last;

    // table model
    bit [TICK_W-1:0]      tick_now = '0;
    bit                   slot_live [SLOTS] = '{default: 1'b0};
    bit [ID_W-1:0]        slot_id   [SLOTS];
    bit [TICK_W-1:0]      slot_due  [SLOTS];

    request_t             req_q[$];
    alarm_result_t        expected_q[$];
    request_t             cur;
    int unsigned          idle_run = 0;
    int unsigned          gap_mode = 1;
    int unsigned          n_total = 0;
    int unsigned          n_accepted = 0;
    int unsigned          n_predicted = 0;
    int unsigned          n_checked = 0;
    int unsigned          cyc = 0;
    int unsigned          quiet_cycles = 0;
    int                   n_errors = 0;

    alarm_table_tick_dispatch_unit #(
        .ALARM_SLOTS   (SLOTS),
        .EVENT_ID_BITS (ID_W)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .event_id       (event_id),
        .delay_secs     (delay_secs),
        .delay_usecs    (delay_usecs),
        .result_strobe  (result_strobe),
        .status         (status),
        .alarm_event    (alarm_event),
        .remaining_secs (remaining_secs),
        .last           (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Applies one accepted request to the model and queues the results it causes.
    task automatic alarm_table_predict(input request_t r, output int unsigned produced);
        alarm_result_t burst[$];
        alarm_result_t res;
        int            pick;
        int            i;
        res.stamp  = cyc;
        res.ev     = r.ev;
        res.rem    = '0;
        res.last   = 1'b1;
        res.status = ST_NOT_FOUND;
        pick       = -1;
        case (r.cmd)
            CMD_ADD:
            begin
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        pick = i;
                if (pick < 0)
                    res.status = ST_FULL;
                else
                begin
                    slot_live[pick] = 1'b1;
                    slot_id[pick]   = r.ev;
                    slot_due[pick]  = TICK_W'(r.secs) * MS_PER_SEC
                                    + TICK_W'(r.usecs) / US_PER_MS + tick_now;
                    res.status      = ST_ADDED;
                end
                burst.push_back(res);
            end
            CMD_CANCEL, CMD_REPORT:
            begin
                for (i = SLOTS - 1; i >= 0; i--)
                    if (slot_live[i] && slot_id[i] == r.ev)
                        pick = i;
                if (pick >= 0)
                begin
                    slot_live[pick] = 1'b0;
                    res.status      = ST_CANCELLED;
                    if (r.cmd == CMD_REPORT && slot_due[pick] >= tick_now)
                        res.rem = REM_W'((slot_due[pick] - tick_now) / MS_PER_SEC + 1);
                end
                burst.push_back(res);
            end
            default:
            begin
                tick_now = tick_now + 1;
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && slot_due[i] <= tick_now && burst.size() < MAX_RESULTS)
                    begin
                        slot_live[i] = 1'b0;
                        res.status   = ST_EXPIRED;
                        res.ev       = slot_id[i];
                        res.last     = 1'b0;
                        burst.push_back(res);
                    end
                end
                if (burst.size() != 0)
                    burst[burst.size() - 1].last = 1'b1;
            end
        endcase
        produced = burst.size();
        foreach (burst[k])
            expected_q.push_back(burst[k]);
    endtask

    task automatic queue_req(input cmd_t c, input bit [ID_W-1:0] ev,
                             input bit [SECS_W-1:0] s, input bit [USECS_W-1:0] u,
                             input bit drain = 1'b0);
        request_t r;
        r.cmd   = c;
        r.ev    = ev;
        r.secs  = s;
        r.usecs = u;
        r.drain = drain;
        case (gap_mode)
            0: r.gap = 0;
            1: r.gap = $urandom_range(0, 17);
            default: r.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
        req_q.push_back(r);
    endtask

    task automatic log_error(input string msg);
        if (n_errors < 10)
            $display("%s", msg);
        n_errors++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drv
        int unsigned made;
        logic        go;
        if (!rst_n)
        begin
            start       <= 1'b0;
            command     <= CMD_TICK;
            event_id    <= '0;
            delay_secs  <= '0;
            delay_usecs <= '0;
            n_accepted  <= 0;
            n_predicted <= 0;
            idle_run = 0;
        end
        else
        begin
            made = 0;
            if (start && !busy)
            begin
                alarm_table_predict(cur, made);
                n_accepted  <= n_accepted + 1;
                n_predicted <= n_predicted + made;
                idle_run = 0;
            end
            go = start && busy;
            if (!go)
            begin
                // a drain request waits for every outstanding result first
                if (req_q.size() != 0 && idle_run >= req_q[0].gap &&
                    !(req_q[0].drain && n_checked != n_predicted + made))
                begin
                    cur = req_q.pop_front();
                    go  = 1'b1;
                end
                else
                    idle_run++;
            end
            start <= go;
            if (go)
            begin
                command     <= cur.cmd;
                event_id    <= cur.ev;
                delay_secs  <= cur.secs;
                delay_usecs <= cur.usecs;
            end
        end
    end

    // result monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin : mon
        alarm_result_t e;
        if (!rst_n)
        begin
            cyc          <= 0;
            n_checked    <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (result_strobe)
            begin
                // entries stamped this cycle belong to a request accepted at this very edge
                if (expected_q.size() == 0 || expected_q[0].stamp == cyc)
                    log_error($sformatf("unexpected result: status=%0d event=%h rem=%0d last=%0d",
                                        status, alarm_event, remaining_secs, last));
                else
                begin
                    e = expected_q.pop_front();
                    n_checked <= n_checked + 1;
                    if (status !== e.status || alarm_event !== e.ev ||
                        remaining_secs !== e.rem || last !== e.last)
                        log_error($sformatf({"result mismatch: expected status=%0d event=%h ",
                                             "rem=%0d last=%0d, got status=%0d event=%h ",
                                             "rem=%0d last=%0d"},
                                            e.status, e.ev, e.rem, e.last,
                                            status, alarm_event, remaining_secs, last));
                end
            end
            if (result_strobe || (start && !busy))
                quiet_cycles <= 0;
            else if (quiet_cycles < STALL_LIMIT)
                quiet_cycles <= quiet_cycles + 1;
            else
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stim
        bit [ID_W-1:0] id_pool[8];
        bit [ID_W-1:0] ev;
        int            k;
        int            pick;
        int            kind;
        foreach (id_pool[j])
            id_pool[j] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;

        // empty table, then fill it past capacity
        gap_mode = 1;
        queue_req(CMD_TICK, 16'hFFFF, '1, '1);
        queue_req(CMD_CANCEL, 16'hFFFF, '0, '0);
        queue_req(CMD_REPORT, 16'h0000, '1, '1);
        queue_req(CMD_ADD, 16'h0000, 0, 0);
        queue_req(CMD_ADD, 16'hFFFF, '1, '1);          // delays beyond their nominal range
        queue_req(CMD_ADD, 16'h1234, 0, 999);          // truncates to zero milliseconds
        queue_req(CMD_ADD, 16'h1234, 0, 1000);         // duplicate id
        queue_req(CMD_ADD, 16'hA5A5, 4000000, 999999);
        queue_req(CMD_ADD, 16'h5A5A, 1, 0);
        for (k = 0; k < 10; k++)
            queue_req(CMD_ADD, ID_W'(16'h0100 + k), 0, USECS_W'(k * 1500));
        queue_req(CMD_ADD, 16'hBEEF, 0, 0);            // table full
        queue_req(CMD_CANCEL, 16'h1234, '1, '1);       // lowest duplicate goes
        queue_req(CMD_REPORT, 16'hFFFF, 0, 0);
        queue_req(CMD_REPORT, 16'h0000, 0, 0);         // due equals now
        queue_req(CMD_TICK, 16'h7777, 0, 0);           // several expire at once
        queue_req(CMD_REPORT, 16'h5A5A, 0, 0);

        for (k = 0; k < 435; k++)
        begin
            if (k % 40 == 0)
                gap_mode = $urandom_range(0, 2);
            ev   = ($urandom_range(0, 9) < 6) ? id_pool[$urandom_range(0, 7)] : ID_W'($urandom);
            pick = $urandom_range(0, 99);
            kind = $urandom_range(0, 19);
            if (pick < 35)
                queue_req(CMD_TICK, ID_W'($urandom), SECS_W'($urandom), USECS_W'($urandom),
                          k == 0 || $urandom_range(0, 39) == 0);
            else if (pick < 70)
            begin
                // mostly short delays so alarms expire within the run
                if (kind < 15)
                    queue_req(CMD_ADD, ev, 0, USECS_W'($urandom_range(0, 30000)));
                else if (kind < 18)
                    queue_req(CMD_ADD, ev, SECS_W'($urandom_range(0, 3)),
                              USECS_W'($urandom_range(0, 999999)));
                else
                    queue_req(CMD_ADD, ev, SECS_W'($urandom), USECS_W'($urandom));
            end
            else
                queue_req(pick < 85 ? CMD_CANCEL : CMD_REPORT, ev,
                          SECS_W'($urandom), USECS_W'($urandom));
        end
        n_total = req_q.size();

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted != n_total || n_checked != n_predicted)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/atd_pkg.sv
sv/atd_ctrl.sv
sv/atd_dpath.sv
sv/alarm_table_tick_dispatch_unit.sv
test/tb_alarm_table_tick_dispatch_unit.sv
